// ===== rtl/ral_pkg.sv =====
// Package for the ranked array list engine: sizes, codes and shared types.
`timescale 1ns / 1ps

package ral_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned RANK_W     = 7;
  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned CMP_W      = (RANK_W > CNT_W) ? RANK_W : CNT_W;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SH,
    S_INS_WR,
    S_REM_FIRST,
    S_REM_SH,
    S_RD_CAP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic [RANK_W-1:0] removed;
    logic [RANK_W-1:0] fill;
    logic              status;
  } result_t;

endpackage

// ===== rtl/ral_mem.sv =====
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ral_mem
  import ral_pkg::*;
(
  input  logic                  clk_i,
  input  mem_req_t              req_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ral_seq.sv =====
// Sequencer: checks an item, then walks the store one element a cycle.
`timescale 1ns / 1ps

module ral_seq
  import ral_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [1:0]            kind_i,
  input  logic [RANK_W-1:0]     rank_i,
  input  logic [RANK_W-1:0]     rank_end_i,
  input  logic [ELEM_W-1:0]     value_i,
  input  logic                  out_free_i,
  input  logic [DATA_WIDTH-1:0] rdata_i,
  output mem_req_t              mem_o,
  output logic                  busy_o,
  output logic                  res_valid_o,
  output result_t               res_o
);

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic [CNT_W-1:0]      dst_q, dst_d;
  logic [CNT_W-1:0]      lo_q, lo_d;
  logic [CNT_W-1:0]      hi_q, hi_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [ELEM_W-1:0]     elem_q, elem_d;
  logic [CNT_W-1:0]      removed_q, removed_d;
  logic                  status_q, status_d;

  logic [CMP_W-1:0] lo_x, hi_x, cnt_x;
  logic [CNT_W-1:0] ptr_step;
  logic             step_down;

  assign lo_x  = CMP_W'(rank_i);
  assign hi_x  = CMP_W'(rank_end_i);
  assign cnt_x = CMP_W'(count_q);

  // shared pointer stepper: down for insert shifting, up for removal
  assign step_down = (state_q == S_INS_SH);
  assign ptr_step  = step_down ? (ptr_q - 1'b1) : (ptr_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    dst_q     <= dst_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    val_q     <= val_d;
    elem_q    <= elem_d;
    removed_q <= removed_d;
    status_q  <= status_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    dst_d     = dst_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    val_d     = val_q;
    elem_d    = elem_q;
    removed_d = removed_q;
    status_d  = status_q;
    mem_o     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          lo_d      = CNT_W'(rank_i);
          hi_d      = CNT_W'(rank_end_i);
          val_d     = DATA_WIDTH'(value_i);
          elem_d    = '0;
          removed_d = '0;
          status_d  = STATUS_OK;
          state_d   = S_DONE;
          unique case (kind_i)
            KIND_INSERT: begin
              if ((count_q >= CAP_CNT) || (lo_x > cnt_x)) begin
                status_d = STATUS_ERR;
              end else if (lo_x == cnt_x) begin
                state_d = S_INS_WR;
              end else begin
                mem_o.re    = 1'b1;
                mem_o.raddr = ADDR_W'(count_q - 1'b1);
                ptr_d       = count_q - 1'b1;
                dst_d       = count_q;
                state_d     = S_INS_SH;
              end
            end
            KIND_REMOVE: begin
              if ((lo_x > hi_x) || (hi_x > cnt_x)) begin
                status_d = STATUS_ERR;
              end else if (lo_x != hi_x) begin
                mem_o.re    = 1'b1;
                mem_o.raddr = ADDR_W'(rank_i);
                state_d     = S_REM_FIRST;
              end
            end
            KIND_READ: begin
              if (lo_x >= cnt_x) begin
                status_d = STATUS_ERR;
              end else begin
                mem_o.re    = 1'b1;
                mem_o.raddr = ADDR_W'(rank_i);
                state_d     = S_RD_CAP;
              end
            end
            default: status_d = STATUS_ERR;
          endcase
        end
      end

      S_INS_SH: begin
        // move the element read last cycle up one place
        mem_o.we    = 1'b1;
        mem_o.waddr = dst_q[ADDR_W-1:0];
        mem_o.wdata = rdata_i;
        if (ptr_q == lo_q) begin
          state_d = S_INS_WR;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = ptr_step[ADDR_W-1:0];
          dst_d       = ptr_q;
          ptr_d       = ptr_step;
        end
      end

      S_INS_WR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = lo_q[ADDR_W-1:0];
        mem_o.wdata = val_q;
        count_d     = count_q + 1'b1;
        state_d     = S_DONE;
      end

      S_REM_FIRST: begin
        elem_d    = ELEM_W'(signed'(rdata_i));
        removed_d = hi_q - lo_q;
        if (hi_q == count_q) begin
          count_d = lo_q;
          state_d = S_DONE;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = hi_q[ADDR_W-1:0];
          ptr_d       = hi_q;
          dst_d       = lo_q;
          state_d     = S_REM_SH;
        end
      end

      S_REM_SH: begin
        // close the gap: element from ptr lands at dst
        mem_o.we    = 1'b1;
        mem_o.waddr = dst_q[ADDR_W-1:0];
        mem_o.wdata = rdata_i;
        if (ptr_step == count_q) begin
          count_d = dst_q + 1'b1;
          state_d = S_DONE;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = ptr_step[ADDR_W-1:0];
          ptr_d       = ptr_step;
          dst_d       = dst_q + 1'b1;
        end
      end

      S_RD_CAP: begin
        elem_d  = ELEM_W'(signed'(rdata_i));
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign res_valid_o    = (state_q == S_DONE) && out_free_i;
  assign res_o.element  = elem_q;
  assign res_o.removed  = RANK_W'(removed_q);
  assign res_o.fill     = RANK_W'(count_q);
  assign res_o.status   = status_q;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_o.we)
    else $error("store written while idle");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("fill count above capacity");

  a_done_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free_i) |=> (state_q == S_IDLE))
    else $error("result handed off but sequencer stuck");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == STATUS_ERR) |-> (removed_q == '0 && elem_q == '0))
    else $error("error result carries data");

  a_count_stable_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i && !$past(busy_o) && status_d == STATUS_ERR)
      |=> $stable(count_q))
    else $error("count changed on an error item");

endmodule

// ===== rtl/ranked_array_list_engine_core.sv =====
// Top level of the ranked array list engine: handshakes, sequencer, store.
`timescale 1ns / 1ps

// Ranked array list engine.
// Input channel (in_valid_i / in_stall_o) takes one item: kind, rank,
// rank_end, value. Output channel (out_valid_o / out_stall_i) returns one
// result per item: element, removed_count, fill_count, status.
// One item at a time: in_stall_o is high from acceptance until the
// sequencer is back in idle. The work per item, acceptance to next
// acceptance, is set by the walk through the store, one element a cycle:
//   insert at rank r into n elements : shift ranks r..n-1 up, write at r
//   remove [r, e) from n elements    : capture rank r, move e..n-1 to r
//   read                             : capture rank r
//   any error, or empty range        : no walk, straight to the result
// The sequencer hands a result into the output register once that register
// is free. A result waiting under out_stall_i does not block the next
// item; the one after that waits until the output register frees.
// Reset clears the fill count, the sequencer state and the output valid
// flag; the store itself is not cleared, only ranks below the fill count
// are ever read.

module ranked_array_list_engine_core
  import ral_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        kind_i,
  input  logic [RANK_W-1:0] rank_i,
  input  logic [RANK_W-1:0] rank_end_i,
  input  logic [ELEM_W-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ELEM_W-1:0] element_o,
  output logic [RANK_W-1:0] removed_count_o,
  output logic [RANK_W-1:0] fill_count_o,
  output logic              status_o
);

  mem_req_t              mem_req;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  busy;
  logic                  res_valid;
  result_t               res;
  logic                  out_free;
  logic                  out_valid_q, out_valid_d;
  result_t               out_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy;

  ral_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && !busy),
    .kind_i      (kind_i),
    .rank_i      (rank_i),
    .rank_end_i  (rank_end_i),
    .value_i     (value_i),
    .out_free_i  (out_free),
    .rdata_i     (rdata),
    .mem_o       (mem_req),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ral_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_comb begin
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign element_o       = out_q.element;
  assign removed_count_o = out_q.removed;
  assign fill_count_o    = out_q.fill;
  assign status_o        = out_q.status;

endmodule
